FILE: hdl/rgb_kernel_convolution_core_macros.svh
// Assertion macros shared by the convolution core
`ifndef RGB_KERNEL_CONVOLUTION_CORE_MACROS_SVH
`define RGB_KERNEL_CONVOLUTION_CORE_MACROS_SVH

// Check a property at every clock while out of reset
`define RGBKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next clock
`define RGBKC_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rgbkc_pkg.sv
// Shared types and constants of the convolution core
package rgbkc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FIFO_DEPTH    = 8;

  localparam logic [10:0] WIDTH_RST    = 11'd640;
  localparam logic [15:0] HEIGHT_RST   = 16'd480;
  localparam logic [47:0] COEF_TOP_RST = 48'h0;
  localparam logic [47:0] COEF_MID_RST = 48'h0000_0100_0000;
  localparam logic [47:0] COEF_BOT_RST = 48'h0;

  // red in 23:16, green in 15:8, blue in 7:0
  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic valid;
    logic flush;
    logic emit;
    logic interior;
    logic frame_end;
    logic use_older;
  } item_ctrl_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

endpackage

FILE: hdl/rgbkc_if.sv
// Stream interfaces for pixel words and result words
interface rgbkc_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output cmd, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input cmd, input red_in, input green_in,
                input blue_in, output ready);
endinterface

interface rgbkc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

FILE: hdl/rgbkc_ram.sv
// Simple dual-port RAM with registered read, read-first on collision
module rgbkc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/rgbkc_front.sv
// Front end: raster positions, pending count and classification of each word
module rgbkc_front #(
  parameter int MAX_WIDTH = rgbkc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         cmd_i,
  input  rgbkc_pkg::pix_t              pix_i,
  input  logic [10:0]                  width_i,
  input  logic [15:0]                  height_i,
  output logic                         ready_o,
  output rgbkc_pkg::item_ctrl_t        ctrl_o,
  output logic [$clog2(MAX_WIDTH)-1:0] addr_o,
  output rgbkc_pkg::pix_t              pix_o
);
  import rgbkc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int PW     = $clog2(MAX_WIDTH + 2);
  localparam int TW     = CW + 2;
  localparam int SW     = $clog2(ADDR_W);
  localparam int RW     = ADDR_W + CW;
  localparam logic CMD_FLUSH = 1'b1;

  logic [ADDR_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [15:0]       in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]     pend_q, pend_d;

  logic [CW-1:0]     w;
  logic [15:0]       h;
  logic [PW-1:0]     wp1, pc;
  logic              interior, frame_end, emit, use_older;
  logic [TW-1:0]     t0, t1, t2;
  logic [ADDR_W-1:0] addr;

  // input column reduced modulo the width after a width change
  logic [ADDR_W-1:0] rem_q;
  logic [CW-1:0]     red_w_q;
  logic [SW-1:0]     red_step_q;
  logic              red_busy_q, red_done_q;
  logic              col_big, red_ok;
  logic [ADDR_W-1:0] col_base;
  logic [RW-1:0]     red_sub;

  always_comb begin
    if (width_i == 11'd0) begin
      w = CW'(1);
    end else if (32'(width_i) > 32'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(width_i);
    end
    h   = (height_i == 16'd0) ? 16'd1 : height_i;
    wp1 = PW'(w) + PW'(1);
    pc  = (pend_q > wp1) ? wp1 : pend_q;

    interior = (w >= CW'(3)) && (h >= 16'd3) && (out_row_q >= 16'd1) &&
               (out_row_q <= h - 16'd2) && (out_col_q != '0) &&
               (CW'(out_col_q) <= w - CW'(2));
    frame_end = (out_row_q >= h - 16'd1) && (CW'(out_col_q) >= w - CW'(1));
    use_older = (pc > PW'(w));

    col_big  = (CW'(in_col_q) >= w);
    red_ok   = red_done_q && (red_w_q == w);
    ready_o  = !col_big || red_ok;
    col_base = col_big ? rem_q : in_col_q;
    red_sub  = RW'(red_w_q) << red_step_q;

    // column of the oldest pending pixel, reduced modulo the width
    t0 = TW'(col_base) + (TW'(w) << 1) + TW'(1) - TW'(pc);
    t1 = (t0 >= TW'(w)) ? t0 - TW'(w) : t0;
    t2 = (t1 >= TW'(w)) ? t1 - TW'(w) : t1;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    pend_d    = pc;
    emit      = 1'b0;

    if (cmd_i == CMD_FLUSH) begin
      addr = ADDR_W'(t2);
      emit = (pc != '0) && !interior;
      if (emit) begin
        pend_d = pc - PW'(1);
      end
    end else begin
      addr = in_col_q;
      if (CW'(in_col_q) + CW'(1) >= w) begin
        in_col_d = '0;
        in_row_d = (17'(in_row_q) + 17'd1 >= 17'(h)) ? 16'd0 : in_row_q + 16'd1;
      end else begin
        in_col_d = in_col_q + ADDR_W'(1);
      end
      emit = (pc == wp1);
      if (!emit) begin
        pend_d = pc + PW'(1);
      end
    end

    if (emit) begin
      if (CW'(out_col_q) + CW'(1) >= w) begin
        out_col_d = '0;
        out_row_d = (17'(out_row_q) + 17'd1 >= 17'(h)) ? 16'd0 : out_row_q + 16'd1;
      end else begin
        out_col_d = out_col_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      pend_q     <= '0;
      ctrl_o     <= '0;
      rem_q      <= '0;
      red_w_q    <= '0;
      red_step_q <= '0;
      red_busy_q <= 1'b0;
      red_done_q <= 1'b0;
    end else begin
      // drop flush words that release nothing
      ctrl_o.valid <= accept_i && ((cmd_i != CMD_FLUSH) || emit);
      if (accept_i) begin
        in_col_q         <= in_col_d;
        in_row_q         <= in_row_d;
        out_col_q        <= out_col_d;
        out_row_q        <= out_row_d;
        pend_q           <= pend_d;
        ctrl_o.flush     <= (cmd_i == CMD_FLUSH);
        ctrl_o.emit      <= emit;
        ctrl_o.interior  <= interior;
        ctrl_o.frame_end <= frame_end;
        ctrl_o.use_older <= use_older;
      end
      if (accept_i && (cmd_i != CMD_FLUSH)) begin
        red_busy_q <= 1'b0;
        red_done_q <= 1'b0;
      end else if (col_big && !red_ok) begin
        if (!red_busy_q || (red_w_q != w)) begin
          rem_q      <= in_col_q;
          red_w_q    <= w;
          red_step_q <= SW'(ADDR_W - 1);
          red_busy_q <= 1'b1;
          red_done_q <= 1'b0;
        end else begin
          // one restoring subtraction per clock, highest multiple first
          if (RW'(rem_q) >= red_sub) begin
            rem_q <= rem_q - ADDR_W'(red_sub);
          end
          if (red_step_q == '0) begin
            red_busy_q <= 1'b0;
            red_done_q <= 1'b1;
          end else begin
            red_step_q <= red_step_q - SW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      addr_o <= addr;
      pix_o  <= pix_i;
    end
  end

endmodule

FILE: hdl/rgbkc_back.sv
// Back end: line store, 3x3 window, multiply stage and sum/clamp stage
module rgbkc_back #(
  parameter int MAX_WIDTH = rgbkc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rgbkc_pkg::item_ctrl_t        ctrl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  rgbkc_pkg::pix_t              pix_i,
  input  logic [47:0]                  coef_top_i,
  input  logic [47:0]                  coef_mid_i,
  input  logic [47:0]                  coef_bot_i,
  output logic                         res_valid_o,
  output rgbkc_pkg::result_t           res_o,
  output logic [1:0]                   inflight_o
);
  import rgbkc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);

  // stage A: line store data available
  item_ctrl_t        a_ctrl_q;
  logic [ADDR_W-1:0] a_addr_q;
  pix_t              a_pix_q;
  logic [47:0]       ram_rdata, rd;
  pix_t              older, newer;
  logic              we;

  logic              byp_valid_q;
  logic [ADDR_W-1:0] byp_addr_q;
  logic [47:0]       byp_data_q;

  pix_t              win_q [9];

  // stage B: window ready, products formed
  item_ctrl_t        b_ctrl_q, b_ctrl_d;
  pix_t              b_pass_q;
  logic [47:0]       coef [3];
  logic signed [16:0] prod_d [3][9];

  // stage C: products registered, summed and clamped
  item_ctrl_t        c_ctrl_q;
  pix_t              c_pass_q;
  logic signed [16:0] c_prod_q [3][9];
  logic signed [20:0] sum [3];
  logic [7:0]        clamped [3];

  logic signed [24:0] prod;
  logic signed [24:0] rnd;
  logic [7:0]        pch;
  logic [15:0]       wt;

  rgbkc_ram #(
    .WIDTH (48),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (a_addr_q),
    .wdata_i ({newer, a_pix_q}),
    .raddr_i (addr_i),
    .rdata_o (ram_rdata)
  );

  // forward the previous write when it hit the same column
  assign rd    = (byp_valid_q && (byp_addr_q == a_addr_q)) ? byp_data_q : ram_rdata;
  assign older = rd[47:24];
  assign newer = rd[23:0];
  assign we    = a_ctrl_q.valid && !a_ctrl_q.flush;

  always_comb begin
    b_ctrl_d       = a_ctrl_q;
    b_ctrl_d.valid = a_ctrl_q.valid && a_ctrl_q.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q    <= '0;
      b_ctrl_q    <= '0;
      c_ctrl_q    <= '0;
      byp_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      a_ctrl_q    <= ctrl_i;
      b_ctrl_q    <= b_ctrl_d;
      c_ctrl_q    <= b_ctrl_q;
      byp_valid_q <= we;
      if (we) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= older;
        win_q[5] <= newer;
        win_q[8] <= a_pix_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_addr_q   <= addr_i;
    a_pix_q    <= pix_i;
    byp_addr_q <= a_addr_q;
    byp_data_q <= {newer, a_pix_q};
    b_pass_q   <= a_ctrl_q.use_older ? older : newer;
    c_pass_q   <= b_ctrl_q.flush ? b_pass_q : win_q[4];
    c_prod_q   <= prod_d;
  end

  assign coef[0] = coef_top_i;
  assign coef[1] = coef_mid_i;
  assign coef[2] = coef_bot_i;

  // Q8.8 products, truncated toward zero
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        pch  = win_q[k][(2-ch)*8 +: 8];
        wt   = coef[k/3][(k%3)*16 +: 16];
        prod = $signed({1'b0, pch}) * $signed(wt);
        rnd  = prod + (prod[24] ? 25'sd255 : 25'sd0);
        prod_d[ch][k] = rnd[24:8];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum[ch] = sum[ch] + {{4{c_prod_q[ch][k][16]}}, c_prod_q[ch][k]};
      end
      if (sum[ch][20]) begin
        clamped[ch] = 8'd0;
      end else if (sum[ch] > 21'sd255) begin
        clamped[ch] = 8'd255;
      end else begin
        clamped[ch] = sum[ch][7:0];
      end
    end
  end

  assign res_valid_o     = c_ctrl_q.valid;
  assign res_o.frame_end = c_ctrl_q.frame_end;
  assign res_o.red       = c_ctrl_q.interior ? clamped[0] : c_pass_q[23:16];
  assign res_o.green     = c_ctrl_q.interior ? clamped[1] : c_pass_q[15:8];
  assign res_o.blue      = c_ctrl_q.interior ? clamped[2] : c_pass_q[7:0];

  assign inflight_o = 2'(a_ctrl_q.valid && a_ctrl_q.emit) + 2'(b_ctrl_q.valid) +
                      2'(c_ctrl_q.valid);

endmodule

FILE: hdl/rgbkc_fifo.sv
// Result queue between the arithmetic pipeline and the output channel
module rgbkc_fifo #(
  parameter int DEPTH = rgbkc_pkg::FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  rgbkc_pkg::result_t         data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output rgbkc_pkg::result_t         data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  import rgbkc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/rgb_kernel_convolution_core.sv
// Top level of the 3x3 RGB convolution core with its register port
// Accepts one word per clock and delivers one result per clock while the result
// sink keeps up. A word passes a front register, the line-store read, a window
// stage, a multiply stage and a sum/clamp stage before its result is written into
// the output queue; the stream itself lags by one row plus one pixel, and flush
// words drain the tail. Input ready follows the free space of the eight-word
// output queue counted against words still in the pipeline, so a stalled sink
// stops input after at most eight pending results. After a width change that
// leaves the input column at or beyond the new width, input holds while that
// column is reduced modulo the width.
// The line store is one 48-bit RAM of MAX_WIDTH entries; it needs no clearing.
module rgb_kernel_convolution_core #(
  parameter int MAX_WIDTH = rgbkc_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rgbkc_pix_if.sink   pix_i,
  rgbkc_res_if.source res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import rgbkc_pkg::*;

  `include "rgb_kernel_convolution_core_macros.svh"

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_COEF_TOP = 3'd2,
    REG_COEF_MID = 3'd3,
    REG_COEF_BOT = 3'd4
  } reg_idx_e;

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [47:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic        wr_en;
  reg_idx_e    reg_idx;

  item_ctrl_t        front_ctrl;
  logic [ADDR_W-1:0] front_addr;
  pix_t              front_pix;
  logic              front_ready;
  logic              accept;

  logic              back_valid;
  result_t           back_res;
  logic [1:0]        back_inflight;

  logic              fifo_valid;
  result_t           fifo_data;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W:0]    occupancy;
  logic              pop;

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      coef_top_q <= COEF_TOP_RST;
      coef_mid_q <= COEF_MID_RST;
      coef_bot_q <= COEF_BOT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:    width_q    <= pwdata[10:0];
        REG_HEIGHT:   height_q   <= pwdata[15:0];
        REG_COEF_TOP: coef_top_q <= pwdata[47:0];
        REG_COEF_MID: coef_mid_q <= pwdata[47:0];
        REG_COEF_BOT: coef_bot_q <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:    prdata = 64'(width_q);
      REG_HEIGHT:   prdata = 64'(height_q);
      REG_COEF_TOP: prdata = 64'(coef_top_q);
      REG_COEF_MID: prdata = 64'(coef_mid_q);
      REG_COEF_BOT: prdata = 64'(coef_bot_q);
      default:      prdata = '0;
    endcase
  end

  // hold input while queue space is promised to words in flight
  assign occupancy   = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(front_ctrl.valid && front_ctrl.emit) +
                       (CNT_W+1)'(back_inflight);
  assign pix_i.ready = (occupancy < (CNT_W+1)'(FIFO_DEPTH)) && front_ready;
  assign accept      = pix_i.valid && pix_i.ready;

  rgbkc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (pix_i.cmd),
    .pix_i    ({pix_i.red_in, pix_i.green_in, pix_i.blue_in}),
    .width_i  (width_q),
    .height_i (height_q),
    .ready_o  (front_ready),
    .ctrl_o   (front_ctrl),
    .addr_o   (front_addr),
    .pix_o    (front_pix)
  );

  rgbkc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (front_ctrl),
    .addr_i      (front_addr),
    .pix_i       (front_pix),
    .coef_top_i  (coef_top_q),
    .coef_mid_i  (coef_mid_q),
    .coef_bot_i  (coef_bot_q),
    .res_valid_o (back_valid),
    .res_o       (back_res),
    .inflight_o  (back_inflight)
  );

  assign pop = res_o.valid && res_o.ready;

  rgbkc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_res),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .count_o (fifo_count)
  );

  assign res_o.valid     = fifo_valid;
  assign res_o.red_out   = fifo_data.red;
  assign res_o.green_out = fifo_data.green;
  assign res_o.blue_out  = fifo_data.blue;
  assign res_o.frame_end = fifo_data.frame_end;

  `RGBKC_ASSERT(a_credit_bound, occupancy <= (CNT_W+1)'(FIFO_DEPTH), "queue credit overrun")
  `RGBKC_ASSERT(a_no_overflow, !(back_valid && !pop && fifo_count == CNT_W'(FIFO_DEPTH)), "result queue overflow")
  `RGBKC_ASSERT_NEXT(a_flush_emits, accept && pix_i.cmd, !front_ctrl.valid || front_ctrl.emit, "flush word queued without a result")

endmodule
